/* rtl/pidiz_pkg.sv */
// Package for the PID controller with integral zone.
// Holds data widths, register indexes and the sequencer state encoding.
// No dependencies.
`default_nettype none
package pidiz_pkg;

  localparam int DataW   = 32;                   // Q16.16 value width
  localparam int FracW   = 16;                   // fraction bits
  localparam int DivNW   = DataW + 1 + FracW;    // |delta| << FRAC dividend width
  localparam int DivDW   = DataW + 6;            // elapsed_time * 50 width
  localparam int ProdW   = 2 * DataW;            // full product width
  localparam int TermW   = ProdW - FracW;        // product >> FRAC width
  localparam int AccW    = TermW + 2;            // P + I - D
  localparam int DriveW  = 18;
  localparam int LimitW  = 17;
  localparam int CountW  = 16;
  localparam int IndexW  = 3;
  localparam logic [LimitW-1:0] LimitOne = LimitW'(1 << FracW);

  typedef enum logic [IndexW-1:0] {
    REG_GAIN_P        = 3'd0,
    REG_GAIN_I        = 3'd1,
    REG_GAIN_D        = 3'd2,
    REG_ERROR_BAND    = 3'd3,
    REG_INTEGRAL_ZONE = 3'd4,
    REG_MAX_INCREMENT = 3'd5,
    REG_OUTPUT_LIMIT  = 3'd6,
    REG_SETTLE_STEPS  = 3'd7
  } reg_index_t;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_ERR  = 8'b0000_0010,
    S_INT  = 8'b0000_0100,
    S_DIV  = 8'b0000_1000,
    S_MULP = 8'b0001_0000,
    S_MULI = 8'b0010_0000,
    S_MULD = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_t;

endpackage
`default_nettype wire

/* rtl/pidiz_mul.sv */
// Bit-serial signed multiplier, one multiplier bit per cycle.
// Depends on pidiz_pkg.
`default_nettype none
module pidiz_mul (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  input  wire logic signed [pidiz_pkg::DataW-1:0]  a,
  input  wire logic signed [pidiz_pkg::DataW-1:0]  b,
  output logic                                     done,
  output logic        [pidiz_pkg::ProdW-1:0]       product
);
  import pidiz_pkg::*;

  localparam int CntW = $clog2(DataW);

  logic                    busy;
  logic [CntW-1:0]         cnt;
  logic signed [DataW-1:0] mcand;
  logic signed [DataW:0]   hi;
  logic [DataW-1:0]        lo;
  logic signed [DataW:0]   addend;
  logic signed [DataW:0]   hi_sum;
  logic                    last;

  assign last = (cnt == CntW'(DataW - 1));

  // The sign bit of the multiplier carries negative weight.
  always_comb begin
    if (!lo[0]) begin
      addend = '0;
    end else if (last) begin
      addend = -{mcand[DataW-1], mcand};
    end else begin
      addend = {mcand[DataW-1], mcand};
    end
    hi_sum = hi + addend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        mcand <= a;
        hi    <= '0;
        lo    <= b;
      end else if (busy) begin
        hi  <= {hi_sum[DataW], hi_sum[DataW:1]};
        lo  <= {hi_sum[0], lo[DataW-1:1]};
        cnt <= cnt + 1'b1;
        if (last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign product = {hi[DataW-1:0], lo};

endmodule
`default_nettype wire

/* rtl/pidiz_div.sv */
// Bit-serial restoring divider for unsigned operands, one quotient bit per cycle.
// Depends on pidiz_pkg.
`default_nettype none
module pidiz_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [pidiz_pkg::DivNW-1:0]   dividend,
  input  wire logic [pidiz_pkg::DivDW-1:0]   divisor,
  output logic                               done,
  output logic      [pidiz_pkg::DivNW-1:0]   quotient
);
  import pidiz_pkg::*;

  localparam int CntW = $clog2(DivNW);

  logic             busy;
  logic [CntW-1:0]  cnt;
  logic [DivDW-1:0] den;
  logic [DivDW-1:0] rem;
  logic [DivNW-1:0] num;
  logic [DivDW:0]   trial;
  logic [DivDW:0]   diff;
  logic             ge;
  logic             last;

  assign last  = (cnt == CntW'(DivNW - 1));
  assign trial = {rem, num[DivNW-1]};
  assign ge    = (trial >= {1'b0, den});
  assign diff  = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        den  <= divisor;
        rem  <= '0;
        num  <= dividend;
      end else if (busy) begin
        // shift the quotient bit in where the dividend bit left
        rem <= ge ? diff[DivDW-1:0] : trial[DivDW-1:0];
        num <= {num[DivNW-2:0], ge};
        cnt <= cnt + 1'b1;
        if (last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = num;

endmodule
`default_nettype wire

/* rtl/pid_controller_with_izone_core.sv */
// PID controller with integral zone: sequencer, state and configuration registers.
// Depends on pidiz_pkg, pidiz_mul and pidiz_div.
//
// A transaction runs through the error and integral setup states, the
// derivative divide, the three gain products and a final state that loads
// the output register. The divide is skipped on a setpoint change or on zero
// elapsed time. The divider and the single shared multiplier are both
// bit-serial. The block takes one transaction at a time. A finished result
// waits in an output register while the next transaction is accepted. That
// next result holds in its final state for as long as the earlier one is stalled.
`default_nettype none
module pid_controller_with_izone_core (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic signed [pidiz_pkg::DataW-1:0]   measurement,
  input  wire logic signed [pidiz_pkg::DataW-1:0]   setpoint,
  input  wire logic        [pidiz_pkg::DataW-1:0]   elapsed_time,
  input  wire logic                                 clear_integral,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [pidiz_pkg::DriveW-1:0]       drive,
  output logic                                      settled,
  input  wire logic                                 wr_en,
  input  wire logic [pidiz_pkg::IndexW-1:0]         wr_index,
  input  wire logic [pidiz_pkg::DataW-1:0]          wr_data
);
  import pidiz_pkg::*;

  // configuration
  logic signed [DataW-1:0] gain_p, gain_i, gain_d;
  logic [DataW-2:0]        error_band, integral_zone, max_increment;
  logic [LimitW-1:0]       output_limit;
  logic [CountW-1:0]       settle_steps;

  // controller state
  logic signed [DataW-1:0] previous_measurement, previous_setpoint, integral_sum;
  logic                    first_step;
  logic [CountW-1:0]       settle_count;

  // transaction registers
  state_t                  state;
  logic signed [DataW-1:0] meas, setp, err, vel;
  logic [DataW-1:0]        etime;
  logic                    clr, d_en, in_band, launched, settled_r;
  logic signed [DataW:0]   delta;
  logic [DivDW-1:0]        divisor;
  logic signed [AccW-1:0]  acc;

  // combinational
  logic signed [DataW:0]   err_raw, mdiff, band_s, maxinc_s, err_x, inc, abs_err;
  logic signed [DataW+1:0] isum;
  logic signed [DataW-1:0] err_sat, int_next;
  logic signed [DataW-1:0] prev_used;
  logic [DataW:0]          mag;
  logic [DivNW-1:0]        quotient;
  logic signed [DataW-1:0] vel_sat;
  logic                    div_start, div_done, mul_start, mul_done;
  logic signed [DataW-1:0] mul_a, mul_b;
  logic [ProdW-1:0]        product;
  logic signed [AccW-1:0]  term, lim_s;
  logic signed [DriveW-1:0] drive_next;

  assign in_stall = (state != S_IDLE);

  assign err_raw = {setp[DataW-1], setp} - {meas[DataW-1], meas};
  assign mdiff   = -err_raw;
  assign band_s  = {2'b00, error_band};
  assign maxinc_s = {2'b00, max_increment};

  always_comb begin
    if (err_raw[DataW] != err_raw[DataW-1]) begin
      err_sat = err_raw[DataW] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
    end else begin
      err_sat = err_raw[DataW-1:0];
    end
  end

  assign prev_used = first_step ? meas : previous_measurement;

  // integral update with per-step limit, band reset and zone reset
  always_comb begin
    err_x = {err[DataW-1], err};
    if (err_x >= band_s) begin
      inc = (err_x < maxinc_s) ? err_x : maxinc_s;
    end else if (err_x <= -band_s) begin
      inc = (err_x > -maxinc_s) ? err_x : -maxinc_s;
    end else begin
      inc = '0;
    end
    isum = {{2{integral_sum[DataW-1]}}, integral_sum} + {inc[DataW], inc};
    if (!(err_x >= band_s) && !(err_x <= -band_s)) begin
      int_next = '0;
    end else if (isum > (DataW+2)'(signed'({1'b0, {(DataW-1){1'b1}}}))) begin
      int_next = {1'b0, {(DataW-1){1'b1}}};
    end else if (isum < -(DataW+2)'(signed'({2'b01, {(DataW-1){1'b0}}}))) begin
      int_next = {1'b1, {(DataW-1){1'b0}}};
    end else begin
      int_next = isum[DataW-1:0];
    end
    abs_err = err_x[DataW] ? -err_x : err_x;
    if ((integral_zone != '0) && (abs_err > {2'b00, integral_zone})) begin
      int_next = '0;
    end
  end

  // velocity: sign back on, saturate
  always_comb begin
    if (!delta[DataW]) begin
      vel_sat = (quotient > DivNW'({1'b0, {(DataW-1){1'b1}}})) ?
                {1'b0, {(DataW-1){1'b1}}} : quotient[DataW-1:0];
    end else begin
      vel_sat = (quotient > DivNW'({1'b1, {(DataW-1){1'b0}}})) ?
                {1'b1, {(DataW-1){1'b0}}} : -quotient[DataW-1:0];
    end
  end

  assign mag = delta[DataW] ? -delta : delta;

  assign div_start = (state == S_DIV) && !launched;
  assign mul_start = ((state == S_MULP) || (state == S_MULI) || (state == S_MULD)) && !launched;

  always_comb begin
    unique case (state)
      S_MULI: begin
        mul_a = gain_i;
        mul_b = integral_sum;
      end
      S_MULD: begin
        mul_a = gain_d;
        mul_b = vel;
      end
      default: begin
        mul_a = gain_p;
        mul_b = err;
      end
    endcase
  end

  assign term  = {{2{product[ProdW-1]}}, product[ProdW-1:FracW]};
  assign lim_s = {{(AccW-LimitW){1'b0}}, output_limit};

  always_comb begin
    if (acc > lim_s) begin
      drive_next = lim_s[DriveW-1:0];
    end else if (acc < -lim_s) begin
      drive_next = -lim_s[DriveW-1:0];
    end else begin
      drive_next = acc[DriveW-1:0];
    end
  end

  pidiz_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({mag, {FracW{1'b0}}}),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  pidiz_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (product)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p               <= '0;
      gain_i               <= '0;
      gain_d               <= '0;
      error_band           <= '0;
      integral_zone        <= '0;
      max_increment        <= (DataW-1)'(1 << FracW);
      output_limit         <= LimitOne;
      settle_steps         <= CountW'(10);
      previous_measurement <= '0;
      previous_setpoint    <= '0;
      first_step           <= 1'b1;
      integral_sum         <= '0;
      settle_count         <= '0;
      state                <= S_IDLE;
      launched             <= 1'b0;
      out_valid            <= 1'b0;
    end else begin
      if (wr_en) begin
        unique case (reg_index_t'(wr_index))
          REG_GAIN_P:        gain_p        <= wr_data;
          REG_GAIN_I:        gain_i        <= wr_data;
          REG_GAIN_D:        gain_d        <= wr_data;
          REG_ERROR_BAND:    error_band    <= wr_data[DataW-2:0];
          REG_INTEGRAL_ZONE: integral_zone <= wr_data[DataW-2:0];
          REG_MAX_INCREMENT: max_increment <= wr_data[DataW-2:0];
          REG_OUTPUT_LIMIT: begin
            // drop limits above 1.0
            if (wr_data[LimitW-1:0] <= LimitOne) begin
              output_limit <= wr_data[LimitW-1:0];
            end
          end
          REG_SETTLE_STEPS:  settle_steps  <= wr_data[CountW-1:0];
          default: ;
        endcase
      end

      if (out_valid && !out_stall && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            meas  <= measurement;
            setp  <= setpoint;
            etime <= elapsed_time;
            clr   <= clear_integral;
            state <= S_ERR;
          end
        end
        S_ERR: begin
          err        <= err_sat;
          delta      <= {meas[DataW-1], meas} - {prev_used[DataW-1], prev_used};
          first_step <= (previous_setpoint != setp);
          d_en       <= (previous_setpoint == setp) && (etime != '0);
          divisor    <= ({6'b0, etime} << 5) + ({6'b0, etime} << 4) + ({6'b0, etime} << 1);
          in_band    <= (mdiff <= band_s) && (mdiff >= -band_s);
          previous_measurement <= meas;
          previous_setpoint    <= setp;
          if (clr) begin
            integral_sum <= '0;
          end
          acc   <= '0;
          vel   <= '0;
          state <= S_INT;
        end
        S_INT: begin
          integral_sum <= int_next;
          settled_r    <= in_band && !first_step && (settle_count >= settle_steps);
          if (in_band && !first_step) begin
            if (settle_count >= settle_steps) begin
              settle_count <= '0;
            end else begin
              settle_count <= settle_count + 1'b1;
            end
          end
          state <= d_en ? S_DIV : S_MULP;
        end
        S_DIV: begin
          launched <= !div_done;
          if (div_done) begin
            vel   <= vel_sat;
            state <= S_MULP;
          end
        end
        S_MULP, S_MULI, S_MULD: begin
          launched <= !mul_done;
          if (mul_done) begin
            if (state == S_MULD) begin
              acc   <= acc - term;
              state <= S_OUT;
            end else begin
              acc   <= acc + term;
              state <= (state == S_MULP) ? S_MULI : S_MULD;
            end
          end
        end
        S_OUT: begin
          // hold until the output register is free
          if (!out_valid || !out_stall) begin
            drive     <= drive_next;
            settled   <= settled_r;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/pidiz_checker.sv */
// Port-level checks for the PID controller with integral zone, and their binding.
// Depends on pid_controller_with_izone_core.
`default_nettype none
module pidiz_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [17:0] drive
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result transaction dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again before the transaction finished");

  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a transaction in progress");

  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($signed(drive) <= 18'sd65536) && ($signed(drive) >= -18'sd65536))
    else $error("drive outside the clamp range");

endmodule

bind pid_controller_with_izone_core pidiz_checker u_pidiz_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .drive     (drive)
);
`default_nettype wire

/* bench/tb_top.sv */
// Self-checking bench for pid_controller_with_izone_core: a bit-true PID
// predictor with a result queue, random and directed stimulus, random stalls.
// Depends on pidiz_pkg and the RTL of the controller.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pidiz_pkg::*;

  typedef struct packed {
    logic signed [DriveW-1:0] drive;
    logic                     settled;
  } pid_result_t;

  class pid_scoreboard;
    longint gain_p, gain_i, gain_d, band, zone, max_inc, limit;
    int unsigned settle_steps, settle_count;
    longint prev_meas, prev_setp, integ;
    bit first;
    pid_result_t pending_results[$];
    int mismatches;

    function new();
      gain_p = 0; gain_i = 0; gain_d = 0; band = 0; zone = 0;
      max_inc = 65536; limit = 65536; settle_steps = 10; settle_count = 0;
      prev_meas = 0; prev_setp = 0; integ = 0; first = 1; mismatches = 0;
    endfunction

    function longint clip32(longint x);
      if (x > 64'sh7fffffff) return 64'sh7fffffff;
      if (x < -64'sh80000000) return -64'sh80000000;
      return x;
    endfunction

    function void write_reg(reg_index_t idx, logic [DataW-1:0] v);
      case (idx)
        REG_GAIN_P:        gain_p = longint'($signed(v));
        REG_GAIN_I:        gain_i = longint'($signed(v));
        REG_GAIN_D:        gain_d = longint'($signed(v));
        REG_ERROR_BAND:    band = longint'({33'd0, v[30:0]});
        REG_INTEGRAL_ZONE: zone = longint'({33'd0, v[30:0]});
        REG_MAX_INCREMENT: max_inc = longint'({33'd0, v[30:0]});
        REG_OUTPUT_LIMIT:  if (v[16:0] <= 17'd65536) limit = longint'({47'd0, v[16:0]});
        REG_SETTLE_STEPS:  settle_steps = v[15:0];
        default: ;
      endcase
    endfunction

    function void take_sample(logic signed [DataW-1:0] m, logic signed [DataW-1:0] s,
                              logic [DataW-1:0] t, logic clr);
      longint meas, setp, tm, err, ab, p, i, d, dr, inc, vel;
      pid_result_t r;
      meas = m;
      setp = s;
      tm = longint'({32'd0, t});
      r.settled = 0;
      if (clr) integ = 0;
      if (first) begin
        prev_meas = meas;
        first = 0;
      end
      if (prev_setp != setp) first = 1;
      err = clip32(setp - meas);
      p = (gain_p * err) >>> FracW;
      if (err >= band) begin
        inc = (err < max_inc) ? err : max_inc;
        integ = clip32(integ + inc);
      end else if (err <= -band) begin
        inc = (err > -max_inc) ? err : -max_inc;
        integ = clip32(integ + inc);
      end else begin
        integ = 0;
      end
      ab = (err < 0) ? -err : err;
      if (zone != 0 && ab > zone) integ = 0;
      i = (gain_i * integ) >>> FracW;
      d = 0;
      if (!first && tm != 0) begin
        vel = ((meas - prev_meas) * 65536) / (tm * 50);
        d = (gain_d * clip32(vel)) >>> FracW;
      end
      dr = p + i - d;
      if (dr > limit) dr = limit;
      else if (dr < -limit) dr = -limit;
      prev_meas = meas;
      prev_setp = setp;
      if (meas <= setp + band && meas >= setp - band && !first) begin
        if (settle_count >= settle_steps) begin
          settle_count = 0;
          r.settled = 1;
        end else begin
          settle_count = (settle_count + 1) & 16'hffff;
        end
      end
      r.drive = dr[DriveW-1:0];
      pending_results.push_back(r);
    endfunction

    function void compare_result(logic signed [DriveW-1:0] drv, logic stl);
      pid_result_t e;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result drive=%0d settled=%0b", drv, stl);
        return;
      end
      e = pending_results.pop_front();
      if (e.drive !== drv || e.settled !== stl) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected drive=%0d settled=%0b, got drive=%0d settled=%0b",
                   e.drive, e.settled, drv, stl);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic signed [DataW-1:0] measurement = '0;
  logic signed [DataW-1:0] setpoint = '0;
  logic [DataW-1:0] elapsed_time = '0;
  logic clear_integral = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [DriveW-1:0] drive;
  logic settled;
  logic wr_en = 0;
  logic [IndexW-1:0] wr_index = '0;
  logic [DataW-1:0] wr_data = '0;

  pid_scoreboard model = new();
  int items_sent = 0;
  int results_seen = 0;
  bit quiet;
  assign quiet = (items_sent >= 700 && items_sent < 900);

  pid_controller_with_izone_core dut (
    .clk, .rst, .in_valid, .in_stall, .measurement, .setpoint, .elapsed_time,
    .clear_integral, .out_valid, .out_stall, .drive, .settled,
    .wr_en, .wr_index, .wr_data
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  initial begin
    #12ms;
    $display("Verification failed");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off to back the block up.
  initial begin
    int hold_left;
    bit pressure_done;
    hold_left = 0;
    pressure_done = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1;
        hold_left--;
      end else if (!pressure_done && results_seen >= 450) begin
        pressure_done = 1;
        hold_left = 600;
        out_stall <= 1;
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < 27);
      end
    end
  end

  // Sample outputs at the falling edge, where they are stable.
  always @(negedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      model.compare_result(drive, settled);
      results_seen++;
    end
  end

  task automatic write_reg(reg_index_t idx, logic [DataW-1:0] v);
    wr_en <= 1;
    wr_index <= idx;
    wr_data <= v;
    model.write_reg(idx, v);
    @(posedge clk);
    wr_en <= 0;
    @(posedge clk);
  endtask

  // Called just after a rising edge; returns just after the edge of acceptance.
  task automatic send_item(logic [DataW-1:0] m, logic [DataW-1:0] s,
                           logic [DataW-1:0] t, logic c);
    if (!quiet && $urandom_range(99) < 27) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1;
    measurement <= m;
    setpoint <= s;
    elapsed_time <= t;
    clear_integral <= c;
    do @(negedge clk); while (in_stall);
    model.take_sample(m, s, t, c);
    items_sent++;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (model.pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic random_config(bit extreme);
    logic [DataW-1:0] gmax[4];
    gmax = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, $urandom()};
    if (extreme) begin
      write_reg(REG_GAIN_P, gmax[$urandom_range(3)]);
      write_reg(REG_GAIN_I, gmax[$urandom_range(3)]);
      write_reg(REG_GAIN_D, gmax[$urandom_range(3)]);
      write_reg(REG_ERROR_BAND, $urandom_range(1) ? 32'h7fff_ffff : 32'h0);
      write_reg(REG_INTEGRAL_ZONE, $urandom_range(1) ? 32'h7fff_ffff : 32'h1);
      write_reg(REG_MAX_INCREMENT, $urandom_range(1) ? 32'hffff_ffff : 32'h0);
      write_reg(REG_OUTPUT_LIMIT, $urandom_range(1) ? 32'd65536 : 32'd0);
      write_reg(REG_SETTLE_STEPS, $urandom_range(1) ? 32'hffff : 32'h0);
    end else begin
      write_reg(REG_GAIN_P, 32'($urandom_range(0, 8 * 65536)) - 32'd262144);
      write_reg(REG_GAIN_I, 32'($urandom_range(0, 2 * 65536)) - 32'd65536);
      write_reg(REG_GAIN_D, 32'($urandom_range(0, 8 * 65536)) - 32'd262144);
      write_reg(REG_ERROR_BAND, $urandom_range(0, 16384));
      write_reg(REG_INTEGRAL_ZONE, $urandom_range(1) ? 32'd0 : $urandom_range(0, 4 * 65536));
      write_reg(REG_MAX_INCREMENT, $urandom_range(0, 2 * 65536));
      write_reg(REG_OUTPUT_LIMIT, $urandom_range(0, 65536));
      write_reg(REG_SETTLE_STEPS, $urandom_range(0, 8));
    end
    // Out-of-range limit: must be ignored.
    if ($urandom_range(1)) write_reg(REG_OUTPUT_LIMIT, $urandom() | 32'h0001_0001);
  endtask

  task automatic random_phase(int n);
    logic [DataW-1:0] sp, m, t, noise;
    sp = $urandom_range(0, 8 * 65536) - 4 * 65536;
    repeat (n) begin
      if ($urandom_range(99) < 5)
        sp = $urandom_range(3) == 0 ? $urandom() : $urandom_range(0, 8 * 65536) - 4 * 65536;
      case ($urandom_range(9))
        0:       m = $urandom();
        1, 2:    m = sp + $urandom_range(0, 8 * 65536) - 4 * 65536;
        default: begin
          noise = $urandom_range(0, 40000);
          m = sp + noise - 20000;
        end
      endcase
      case ($urandom_range(9))
        0:       t = 0;
        1:       t = $urandom();
        default: t = $urandom_range(1, 2 * 65536);
      endcase
      send_item(m, sp, t, $urandom_range(99) < 4);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    write_reg(REG_GAIN_P, 32'd65536);
    write_reg(REG_GAIN_I, 32'd32768);
    write_reg(REG_GAIN_D, 32'd65536);
    write_reg(REG_ERROR_BAND, 32'd4096);
    write_reg(REG_INTEGRAL_ZONE, 32'd0);
    write_reg(REG_MAX_INCREMENT, 32'd65536);
    write_reg(REG_OUTPUT_LIMIT, 32'd65536);
    write_reg(REG_SETTLE_STEPS, 32'd2);
    // Directed: first step, settling, extremes, zero and huge time, clear, setpoint change.
    send_item(32'd0, 32'd0, 32'd65536, 0);
    send_item(32'd100, 32'd0, 32'd65536, 0);
    send_item(32'd50, 32'd0, 32'd1, 0);
    send_item(32'd0, 32'd0, 32'd0, 0);
    send_item(32'd10, 32'd0, 32'd65536, 0);
    send_item(32'h8000_0000, 32'd0, 32'd1, 0);
    send_item(32'h7fff_ffff, 32'd0, 32'd1, 0);
    send_item(32'h8000_0000, 32'd0, 32'hffff_ffff, 1);
    send_item(32'h7fff_ffff, 32'h8000_0000, 32'd65536, 0);
    send_item(32'h8000_0000, 32'h7fff_ffff, 32'd65536, 0);
    send_item(32'h8000_0000, 32'h7fff_ffff, 32'd3, 0);
    send_item(32'd0, 32'h7fff_ffff, 32'd65536, 1);
    send_item(32'd65536, 32'd131072, 32'd6554, 0);
    send_item(32'd70000, 32'd131072, 32'd6554, 0);
    send_item(32'd131072, 32'd131072, 32'd6554, 0);
    send_item(32'd131000, 32'd131072, 32'd0, 0);
    send_item(32'd131072, 32'd131072, 32'd6554, 1);
    send_item(32'd131072, 32'd131072, 32'd6554, 0);
    send_item(32'd131072, 32'd131072, 32'd6554, 0);
    drain();
    write_reg(REG_INTEGRAL_ZONE, 32'd1000);
    write_reg(REG_OUTPUT_LIMIT, 32'd0);
    send_item(32'd0, 32'd131072, 32'd65536, 0);
    send_item(32'd130500, 32'd131072, 32'd65536, 0);
    send_item(32'd131072, 32'd131072, 32'd65536, 0);
    drain();

    for (int ph = 0; ph < 13; ph++) begin
      random_config(ph % 4 == 3);
      random_phase(102);
      drain();
    end

    repeat (200) @(posedge clk);
    if (model.mismatches == 0 && model.pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
